### design/swfd_pkg.sv
package swfd_pkg;

    localparam int CMD_W       = 2;
    localparam int BYTE_W      = 8;
    localparam int CIDX_W      = 3;
    localparam int KIND_W      = 2;
    localparam int FIELD_W     = 16;
    localparam int TIME_W      = 64;
    localparam int CVAL_W      = 32;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 32;
    localparam int POS_W       = 5;
    localparam int NUM_CNT     = 8;

    localparam int COUNTER_WIDTH_DEFAULT = 32;
    localparam int HEADER_BYTES          = 18;

    localparam logic [31:0] SYNC_WORD = 32'hBBBB_0000;
    localparam int SYNC_BYTES = 4;

    // header byte positions, counted from the first sync byte
    localparam int HDR_SENDER_LO = 4;
    localparam int HDR_SENDER_HI = 5;
    localparam int HDR_SEQ_LO    = 6;
    localparam int HDR_SEQ_HI    = 7;
    localparam int HDR_LEN_LO    = 8;
    localparam int HDR_LEN_HI    = 9;
    localparam int HDR_TIME_LO   = 10;

    localparam logic [CMD_W-1:0] CMD_DATA = 2'd0;
    localparam logic [CMD_W-1:0] CMD_END  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

    localparam logic [KIND_W-1:0] KIND_HEADER  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ABORT   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_COUNTER = 2'd3;

    localparam logic [CIDX_W-1:0] CNT_RECORDS   = 3'd0;
    localparam logic [CIDX_W-1:0] CNT_SYNC_ERR  = 3'd1;
    localparam logic [CIDX_W-1:0] CNT_BAD_LEN   = 3'd2;
    localparam logic [CIDX_W-1:0] CNT_SHORT_HDR = 3'd3;
    localparam logic [CIDX_W-1:0] CNT_SHORT_PAY = 3'd4;
    localparam logic [CIDX_W-1:0] CNT_RESYNC    = 3'd5;
    localparam logic [CIDX_W-1:0] CNT_DISCARD   = 3'd6;
    localparam logic [CIDX_W-1:0] CNT_RECEIVED  = 3'd7;

    localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RECORD_LIMIT  = 1'd1;

    localparam logic [FIELD_W-1:0]    PAYLOAD_LIMIT_RESET = 16'hFFFF;
    localparam logic [CFG_DATA_W-1:0] RECORD_LIMIT_RESET  = 32'd0;

    localparam logic [2:0] BUMP_ONE         = 3'd1;
    localparam logic [2:0] BUMP_SLIDE_FLUSH = 3'd4;

endpackage

### design/swfd_in_if.sv
interface swfd_in_if;
    logic                           valid;
    logic                           ready;
    logic [swfd_pkg::CMD_W-1:0]     command;
    logic [swfd_pkg::BYTE_W-1:0]    data_byte;
    logic [swfd_pkg::CIDX_W-1:0]    counter_index;

    modport source (output valid, command, data_byte, counter_index, input ready);
    modport sink   (input valid, command, data_byte, counter_index, output ready);
endinterface

### design/swfd_out_if.sv
interface swfd_out_if;
    logic                           valid;
    logic                           ready;
    logic [swfd_pkg::KIND_W-1:0]    kind;
    logic [swfd_pkg::BYTE_W-1:0]    payload_byte;
    logic [swfd_pkg::FIELD_W-1:0]   src_addr;
    logic [swfd_pkg::FIELD_W-1:0]   sequence_number;
    logic [swfd_pkg::FIELD_W-1:0]   body_len;
    logic [swfd_pkg::TIME_W-1:0]    receive_time;
    logic                           last_in_record;
    logic [swfd_pkg::CVAL_W-1:0]    counter_value;

    modport source (output valid, kind, payload_byte, src_addr, sequence_number,
                    body_len, receive_time, last_in_record, counter_value,
                    input ready);
    modport sink   (input valid, kind, payload_byte, src_addr, sequence_number,
                    body_len, receive_time, last_in_record, counter_value,
                    output ready);
endinterface

### design/swfd_cfg_if.sv
interface swfd_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [swfd_pkg::CFG_IDX_W-1:0]     reg_index;
    logic [swfd_pkg::CFG_DATA_W-1:0]    write_data;

    modport source (output valid, reg_index, write_data, input ready);
    modport sink   (input valid, reg_index, write_data, output ready);
endinterface

### design/sync_word_frame_deframer.sv
// Pipeline: an accepted item passes the middle stage register, then the output register.
// Throughput: one item per cycle unless the output stalls; at most one counter memory
// read-modify-write per item, its write-back forwarded to a back-to-back access of the
// same entry. Reset: search restarts at the first window fill, all counters read zero
// (per-entry valid bits), the payload length limit returns to 65535, record limit to 0.
module sync_word_frame_deframer #(
    parameter int COUNTER_WIDTH = swfd_pkg::COUNTER_WIDTH_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    swfd_in_if.sink         link,
    swfd_out_if.source      result,
    swfd_cfg_if.sink        cfg
);

    localparam int CW   = COUNTER_WIDTH;
    localparam int CW1  = COUNTER_WIDTH + 1;
    localparam int CMPW = (COUNTER_WIDTH > 32) ? COUNTER_WIDTH : 32;
    localparam int BW   = swfd_pkg::BYTE_W;
    localparam int FW   = swfd_pkg::FIELD_W;
    localparam int TW   = swfd_pkg::TIME_W;
    localparam int PW   = swfd_pkg::POS_W;
    localparam int IW   = swfd_pkg::CIDX_W;
    localparam int KW   = swfd_pkg::KIND_W;

    typedef enum logic [3:0] {
        PH_FILL    = 4'b0001,
        PH_SLIDE   = 4'b0010,
        PH_HEADER  = 4'b0100,
        PH_PAYLOAD = 4'b1000
    } phase_t;

    // configuration
    logic [FW-1:0] payload_limit_reg;
    logic [31:0]   record_limit_reg;

    // framing state
    phase_t        phase_reg,   phase_next;
    logic [31:0]   window_reg,  window_next;
    logic [PW-1:0] pos_reg,     pos_next;
    logic [FW-1:0] sender_reg,  sender_next;
    logic [FW-1:0] seq_reg,     seq_next;
    logic [FW-1:0] len_reg,     len_next;
    logic [TW-1:0] time_reg,    time_next;
    logic [FW-1:0] remain_reg,  remain_next;

    // counters kept in flops: bumped by data items or needed for the record limit
    logic [CW-1:0] rec_cnt_reg,  rec_cnt_next;
    logic [CW-1:0] rsy_cnt_reg,  rsy_cnt_next;
    logic [CW-1:0] rx_cnt_reg,   rx_cnt_next;

    // counter memory
    logic [CW-1:0]                  cnt_mem [swfd_pkg::NUM_CNT];
    logic [swfd_pkg::NUM_CNT-1:0]   cnt_vld_reg;
    logic [CW-1:0]                  mem_q_reg;
    logic                           mem_v_reg;
    logic                           fwd_hit_reg;
    logic [CW-1:0]                  fwd_val_reg;

    // middle stage
    logic           stg_valid_reg;
    logic           stg_res_reg;
    logic [KW-1:0]  stg_kind_reg;
    logic [BW-1:0]  stg_byte_reg;
    logic [FW-1:0]  stg_sender_reg;
    logic [FW-1:0]  stg_seq_reg;
    logic [FW-1:0]  stg_len_reg;
    logic [TW-1:0]  stg_time_reg;
    logic           stg_last_reg;
    logic           stg_op_reg;
    logic [IW-1:0]  stg_idx_reg;
    logic [2:0]     stg_amt_reg;
    logic           stg_from_flop_reg;
    logic [CW-1:0]  stg_cval_reg;

    // output register
    logic           out_valid_reg;
    logic [KW-1:0]  out_kind_reg;
    logic [BW-1:0]  out_byte_reg;
    logic [FW-1:0]  out_sender_reg;
    logic [FW-1:0]  out_seq_reg;
    logic [FW-1:0]  out_len_reg;
    logic [TW-1:0]  out_time_reg;
    logic           out_last_reg;
    logic [31:0]    out_cval_reg;

    // combinational
    logic           stg_adv;
    logic           accept;
    logic           limit_hit;
    logic           idle_fill;
    logic           res_v;
    logic [KW-1:0]  res_kind;
    logic [BW-1:0]  res_byte;
    logic [FW-1:0]  res_sender;
    logic [FW-1:0]  res_seq;
    logic [FW-1:0]  res_len;
    logic [TW-1:0]  res_time;
    logic           res_last;
    logic           op_en;
    logic [IW-1:0]  op_idx;
    logic [2:0]     op_amt;
    logic [IW-1:0]  rd_addr;
    logic           from_flop;
    logic [CW-1:0]  flop_val;
    logic           rx_bump;
    logic           rsy_bump;
    logic           rec_bump;
    logic [2:0]     tbyte;
    logic [CW-1:0]  cur_val;
    logic [CW1-1:0] sum_wide;
    logic [CW-1:0]  stg_sum;
    logic           stg_wr;

    assign stg_adv    = !out_valid_reg || result.ready;
    assign link.ready = !stg_valid_reg || stg_adv;
    assign accept     = link.valid && link.ready;
    assign cfg.ready  = 1'b1;

    assign limit_hit = (record_limit_reg != '0)
                    && (CMPW'(rec_cnt_reg) >= CMPW'(record_limit_reg));
    assign idle_fill = (phase_reg == PH_FILL) && (pos_reg == '0);
    assign tbyte     = 3'(pos_reg - PW'(swfd_pkg::HDR_TIME_LO));

    always_comb
    begin
        phase_next  = phase_reg;
        window_next = window_reg;
        pos_next    = pos_reg;
        sender_next = sender_reg;
        seq_next    = seq_reg;
        len_next    = len_reg;
        time_next   = time_reg;
        remain_next = remain_reg;
        res_v       = 1'b0;
        res_kind    = swfd_pkg::KIND_HEADER;
        res_byte    = '0;
        res_sender  = '0;
        res_seq     = '0;
        res_len     = '0;
        res_time    = '0;
        res_last    = 1'b0;
        op_en       = 1'b0;
        op_idx      = swfd_pkg::CNT_SYNC_ERR;
        op_amt      = swfd_pkg::BUMP_ONE;
        rx_bump     = 1'b0;
        rsy_bump    = 1'b0;
        rec_bump    = 1'b0;
        if (accept)
        begin
            case (link.command)
                swfd_pkg::CMD_DATA:
                begin
                    if (!(idle_fill && limit_hit))
                    begin
                        rx_bump = 1'b1;
                        case (phase_reg)
                            PH_FILL:
                            begin
                                window_next = {window_reg[23:0], link.data_byte};
                                pos_next    = pos_reg + 1'b1;
                                if (pos_next == PW'(swfd_pkg::SYNC_BYTES))
                                begin
                                    if (window_next == swfd_pkg::SYNC_WORD)
                                    begin
                                        phase_next = PH_HEADER;
                                    end
                                    else
                                    begin
                                        op_en      = 1'b1;
                                        op_idx     = swfd_pkg::CNT_SYNC_ERR;
                                        phase_next = PH_SLIDE;
                                    end
                                end
                            end
                            PH_SLIDE:
                            begin
                                window_next = {window_reg[23:0], link.data_byte};
                                op_en       = 1'b1;
                                op_idx      = swfd_pkg::CNT_DISCARD;
                                if (window_next == swfd_pkg::SYNC_WORD)
                                begin
                                    rsy_bump   = 1'b1;
                                    phase_next = PH_HEADER;
                                    pos_next   = PW'(swfd_pkg::SYNC_BYTES);
                                end
                            end
                            PH_HEADER:
                            begin
                                case (pos_reg) inside
                                    PW'(swfd_pkg::HDR_SENDER_LO):
                                        sender_next[7:0] = link.data_byte;
                                    PW'(swfd_pkg::HDR_SENDER_HI):
                                        sender_next[15:8] = link.data_byte;
                                    PW'(swfd_pkg::HDR_SEQ_LO):
                                        seq_next[7:0] = link.data_byte;
                                    PW'(swfd_pkg::HDR_SEQ_HI):
                                        seq_next[15:8] = link.data_byte;
                                    PW'(swfd_pkg::HDR_LEN_LO):
                                        len_next[7:0] = link.data_byte;
                                    PW'(swfd_pkg::HDR_LEN_HI):
                                        len_next[15:8] = link.data_byte;
                                    [PW'(swfd_pkg::HDR_TIME_LO):PW'(swfd_pkg::HEADER_BYTES-1)]:
                                        time_next[tbyte*BW +: BW] = link.data_byte;
                                    default: ;
                                endcase
                                pos_next = pos_reg + 1'b1;
                                if (pos_reg == PW'(swfd_pkg::HEADER_BYTES-1))
                                begin
                                    if (len_next > payload_limit_reg)
                                    begin
                                        op_en       = 1'b1;
                                        op_idx      = swfd_pkg::CNT_BAD_LEN;
                                        phase_next  = PH_FILL;
                                        pos_next    = '0;
                                        window_next = '0;
                                    end
                                    else
                                    begin
                                        res_v      = 1'b1;
                                        res_kind   = swfd_pkg::KIND_HEADER;
                                        res_sender = sender_next;
                                        res_seq    = seq_next;
                                        res_len    = len_next;
                                        res_time   = time_next;
                                        if (len_next == '0)
                                        begin
                                            res_last    = 1'b1;
                                            rec_bump    = 1'b1;
                                            phase_next  = PH_FILL;
                                            pos_next    = '0;
                                            window_next = '0;
                                        end
                                        else
                                        begin
                                            remain_next = len_next;
                                            phase_next  = PH_PAYLOAD;
                                        end
                                    end
                                end
                            end
                            PH_PAYLOAD:
                            begin
                                res_v       = 1'b1;
                                res_kind    = swfd_pkg::KIND_PAYLOAD;
                                res_byte    = link.data_byte;
                                remain_next = remain_reg - 1'b1;
                                if (remain_next == '0)
                                begin
                                    res_last    = 1'b1;
                                    rec_bump    = 1'b1;
                                    phase_next  = PH_FILL;
                                    pos_next    = '0;
                                    window_next = '0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                swfd_pkg::CMD_END:
                begin
                    if (!idle_fill)
                    begin
                        case (phase_reg)
                            PH_FILL, PH_HEADER:
                            begin
                                op_en  = 1'b1;
                                op_idx = swfd_pkg::CNT_SHORT_HDR;
                            end
                            PH_SLIDE:
                            begin
                                op_en  = 1'b1;
                                op_idx = swfd_pkg::CNT_DISCARD;
                                op_amt = swfd_pkg::BUMP_SLIDE_FLUSH;
                            end
                            default:
                            begin
                                op_en    = 1'b1;
                                op_idx   = swfd_pkg::CNT_SHORT_PAY;
                                res_v    = 1'b1;
                                res_kind = swfd_pkg::KIND_ABORT;
                            end
                        endcase
                        phase_next  = PH_FILL;
                        pos_next    = '0;
                        window_next = '0;
                    end
                end
                swfd_pkg::CMD_READ:
                begin
                    res_v    = 1'b1;
                    res_kind = swfd_pkg::KIND_COUNTER;
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        rd_addr = (link.command == swfd_pkg::CMD_READ) ? link.counter_index : op_idx;
        from_flop = (link.command == swfd_pkg::CMD_READ)
                 && (link.counter_index == swfd_pkg::CNT_RECORDS
                  || link.counter_index == swfd_pkg::CNT_RESYNC
                  || link.counter_index == swfd_pkg::CNT_RECEIVED);
        case (link.counter_index)
            swfd_pkg::CNT_RECORDS: flop_val = rec_cnt_reg;
            swfd_pkg::CNT_RESYNC:  flop_val = rsy_cnt_reg;
            default:               flop_val = rx_cnt_reg;
        endcase
    end

    assign rec_cnt_next = (rec_bump && rec_cnt_reg != '1) ? rec_cnt_reg + 1'b1 : rec_cnt_reg;
    assign rsy_cnt_next = (rsy_bump && rsy_cnt_reg != '1) ? rsy_cnt_reg + 1'b1 : rsy_cnt_reg;
    assign rx_cnt_next  = (rx_bump && rx_cnt_reg != '1) ? rx_cnt_reg + 1'b1 : rx_cnt_reg;

    // read-modify-write of the counter memory
    assign cur_val  = fwd_hit_reg ? fwd_val_reg : (mem_v_reg ? mem_q_reg : '0);
    assign sum_wide = {1'b0, cur_val} + CW1'(stg_amt_reg);
    assign stg_sum  = sum_wide[CW] ? '1 : sum_wide[CW-1:0];
    assign stg_wr   = stg_valid_reg && stg_adv && stg_op_reg;

    always_ff @(posedge clk)
    begin
        if (stg_wr)
        begin
            cnt_mem[stg_idx_reg] <= stg_sum;
        end
        if (accept)
        begin
            mem_q_reg   <= cnt_mem[rd_addr];
            fwd_val_reg <= stg_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_vld_reg <= '0;
            mem_v_reg   <= 1'b0;
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            if (stg_wr)
            begin
                cnt_vld_reg[stg_idx_reg] <= 1'b1;
            end
            if (accept)
            begin
                mem_v_reg   <= cnt_vld_reg[rd_addr];
                fwd_hit_reg <= stg_wr && (stg_idx_reg == rd_addr);
            end
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            payload_limit_reg <= swfd_pkg::PAYLOAD_LIMIT_RESET;
            record_limit_reg  <= swfd_pkg::RECORD_LIMIT_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.reg_index)
                swfd_pkg::REG_PAYLOAD_LIMIT: payload_limit_reg <= cfg.write_data[FW-1:0];
                swfd_pkg::REG_RECORD_LIMIT:  record_limit_reg  <= cfg.write_data;
                default: ;
            endcase
        end
    end

    // framing state and flop counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_FILL;
            window_reg  <= '0;
            pos_reg     <= '0;
            sender_reg  <= '0;
            seq_reg     <= '0;
            len_reg     <= '0;
            time_reg    <= '0;
            remain_reg  <= '0;
            rec_cnt_reg <= '0;
            rsy_cnt_reg <= '0;
            rx_cnt_reg  <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            window_reg  <= window_next;
            pos_reg     <= pos_next;
            sender_reg  <= sender_next;
            seq_reg     <= seq_next;
            len_reg     <= len_next;
            time_reg    <= time_next;
            remain_reg  <= remain_next;
            rec_cnt_reg <= rec_cnt_next;
            rsy_cnt_reg <= rsy_cnt_next;
            rx_cnt_reg  <= rx_cnt_next;
        end
    end

    // middle stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            stg_res_reg   <= 1'b0;
            stg_op_reg    <= 1'b0;
        end
        else if (accept)
        begin
            stg_valid_reg <= 1'b1;
            stg_res_reg   <= res_v;
            stg_op_reg    <= op_en;
        end
        else if (stg_adv)
        begin
            stg_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stg_kind_reg      <= res_kind;
            stg_byte_reg      <= res_byte;
            stg_sender_reg    <= res_sender;
            stg_seq_reg       <= res_seq;
            stg_len_reg       <= res_len;
            stg_time_reg      <= res_time;
            stg_last_reg      <= res_last;
            stg_idx_reg       <= op_idx;
            stg_amt_reg       <= op_amt;
            stg_from_flop_reg <= from_flop;
            stg_cval_reg      <= flop_val;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stg_adv)
        begin
            out_valid_reg <= stg_valid_reg && stg_res_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_adv)
        begin
            out_kind_reg   <= stg_kind_reg;
            out_byte_reg   <= stg_byte_reg;
            out_sender_reg <= stg_sender_reg;
            out_seq_reg    <= stg_seq_reg;
            out_len_reg    <= stg_len_reg;
            out_time_reg   <= stg_time_reg;
            out_last_reg   <= stg_last_reg;
            if (stg_kind_reg == swfd_pkg::KIND_COUNTER)
            begin
                out_cval_reg <= stg_from_flop_reg ? 32'(stg_cval_reg) : 32'(cur_val);
            end
            else
            begin
                out_cval_reg <= '0;
            end
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.kind            = out_kind_reg;
    assign result.payload_byte    = out_byte_reg;
    assign result.src_addr        = out_sender_reg;
    assign result.sequence_number = out_seq_reg;
    assign result.body_len        = out_len_reg;
    assign result.receive_time    = out_time_reg;
    assign result.last_in_record  = out_last_reg;
    assign result.counter_value   = out_cval_reg;

endmodule

### tb/sv/sync_word_frame_deframer_test.sv
module sync_word_frame_deframer_test;

    timeunit 1ns;
    timeprecision 1ps;

    import swfd_pkg::*;

    localparam int          STALL_LIMIT   = 2000;
    localparam int          SETTLE_CYCLES = 8;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic [CVAL_W-1:0] TALLY_MAX = '1;

    typedef enum logic [1:0] {HUNT_FILL, HUNT_SLIDE, TAKE_HEADER, PASS_PAYLOAD} link_state_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [BYTE_W-1:0]  payload_byte;
        logic [FIELD_W-1:0] src_addr;
        logic [FIELD_W-1:0] sequence_number;
        logic [FIELD_W-1:0] body_len;
        logic [TIME_W-1:0]  receive_time;
        logic               last_in_record;
        logic [CVAL_W-1:0]  counter_value;
    } deframe_out_t;

    class deframe_shadow_t;
        logic [FIELD_W-1:0] len_limit;
        logic [CVAL_W-1:0]  rec_limit;
        link_state_t        state;
        logic [31:0]        window;
        int unsigned        pos;
        logic [FIELD_W-1:0] sender;
        logic [FIELD_W-1:0] seq;
        logic [FIELD_W-1:0] len;
        logic [TIME_W-1:0]  stamp;
        logic [FIELD_W-1:0] remaining;
        logic [CVAL_W-1:0]  tally [NUM_CNT];
        deframe_out_t       due_outputs [$];
        int unsigned        failures;

        function new();
            len_limit = PAYLOAD_LIMIT_RESET;
            rec_limit = RECORD_LIMIT_RESET;
            restart_search();
            sender = '0;
            seq = '0;
            len = '0;
            stamp = '0;
            remaining = '0;
            foreach (tally[i])
                tally[i] = '0;
            failures = 0;
        endfunction

        function void restart_search();
            state = HUNT_FILL;
            pos = 0;
            window = '0;
        endfunction

        function void bump(logic [CIDX_W-1:0] idx, logic [2:0] amount);
            if (CVAL_W'(amount) > TALLY_MAX - tally[idx])
                tally[idx] = TALLY_MAX;
            else
                tally[idx] = tally[idx] + CVAL_W'(amount);
        endfunction

        function bit limit_hit();
            return rec_limit != 0 && tally[CNT_RECORDS] >= rec_limit;
        endfunction

        function bit at_search_start();
            return state == HUNT_FILL && pos == 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_PAYLOAD_LIMIT)
                len_limit = data[FIELD_W-1:0];
            else
                rec_limit = data;
        endfunction

        // returns 0 when the block ignores the transfer
        function bit note_link_item(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] b,
                                    logic [CIDX_W-1:0] idx);
            deframe_out_t o;
            bit emit;
            o = '0;
            emit = 0;
            case (cmd)
                CMD_DATA:
                begin
                    if (at_search_start() && limit_hit())
                        return 0;
                    bump(CNT_RECEIVED, BUMP_ONE);
                    case (state)
                        HUNT_FILL:
                        begin
                            window = {window[23:0], b};
                            pos++;
                            if (pos >= SYNC_BYTES)
                            begin
                                if (window == SYNC_WORD)
                                    state = TAKE_HEADER;
                                else
                                begin
                                    bump(CNT_SYNC_ERR, BUMP_ONE);
                                    state = HUNT_SLIDE;
                                end
                            end
                        end
                        HUNT_SLIDE:
                        begin
                            window = {window[23:0], b};
                            bump(CNT_DISCARD, BUMP_ONE);
                            if (window == SYNC_WORD)
                            begin
                                bump(CNT_RESYNC, BUMP_ONE);
                                state = TAKE_HEADER;
                                pos = SYNC_BYTES;
                            end
                        end
                        TAKE_HEADER:
                        begin
                            if (pos == HDR_SENDER_LO)
                            begin
                                sender = {8'h00, b};
                                seq = '0;
                                len = '0;
                                stamp = '0;
                            end
                            else if (pos == HDR_SENDER_HI)
                                sender[15:8] = b;
                            else if (pos == HDR_SEQ_LO)
                                seq = {8'h00, b};
                            else if (pos == HDR_SEQ_HI)
                                seq[15:8] = b;
                            else if (pos == HDR_LEN_LO)
                                len = {8'h00, b};
                            else if (pos == HDR_LEN_HI)
                                len[15:8] = b;
                            else
                                stamp[(pos - HDR_TIME_LO) * 8 +: 8] = b;
                            pos++;
                            if (pos == HEADER_BYTES)
                            begin
                                if (len > len_limit)
                                begin
                                    bump(CNT_BAD_LEN, BUMP_ONE);
                                    restart_search();
                                end
                                else
                                begin
                                    emit = 1;
                                    o.kind = KIND_HEADER;
                                    o.src_addr = sender;
                                    o.sequence_number = seq;
                                    o.body_len = len;
                                    o.receive_time = stamp;
                                    if (len == 0)
                                    begin
                                        o.last_in_record = 1'b1;
                                        bump(CNT_RECORDS, BUMP_ONE);
                                        restart_search();
                                    end
                                    else
                                    begin
                                        remaining = len;
                                        state = PASS_PAYLOAD;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            emit = 1;
                            o.kind = KIND_PAYLOAD;
                            o.payload_byte = b;
                            remaining = remaining - 1'b1;
                            if (remaining == 0)
                            begin
                                o.last_in_record = 1'b1;
                                bump(CNT_RECORDS, BUMP_ONE);
                                restart_search();
                            end
                        end
                    endcase
                end
                CMD_END:
                begin
                    if (at_search_start())
                        return 0;
                    case (state)
                        HUNT_FILL, TAKE_HEADER:
                            bump(CNT_SHORT_HDR, BUMP_ONE);
                        HUNT_SLIDE:
                            bump(CNT_DISCARD, BUMP_SLIDE_FLUSH);
                        default:
                        begin
                            bump(CNT_SHORT_PAY, BUMP_ONE);
                            emit = 1;
                            o.kind = KIND_ABORT;
                        end
                    endcase
                    restart_search();
                end
                CMD_READ:
                begin
                    emit = 1;
                    o.kind = KIND_COUNTER;
                    o.counter_value = tally[idx];
                end
                default:
                    return 0;
            endcase
            if (emit)
                due_outputs.push_back(o);
            return 1;
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
                failures++;
            end
        endfunction

        function void check_output(deframe_out_t got);
            deframe_out_t want;
            if (due_outputs.size() == 0)
            begin
                $error("kind: expected no transfer, actual 0x%0h", got.kind);
                failures++;
                return;
            end
            want = due_outputs.pop_front();
            compare_field("kind", 64'(want.kind), 64'(got.kind));
            compare_field("payload_byte", 64'(want.payload_byte), 64'(got.payload_byte));
            compare_field("src_addr", 64'(want.src_addr), 64'(got.src_addr));
            compare_field("sequence_number", 64'(want.sequence_number),
                          64'(got.sequence_number));
            compare_field("body_len", 64'(want.body_len), 64'(got.body_len));
            compare_field("receive_time", want.receive_time, got.receive_time);
            compare_field("last_in_record", 64'(want.last_in_record),
                          64'(got.last_in_record));
            compare_field("counter_value", 64'(want.counter_value), 64'(got.counter_value));
        endfunction
    endclass

    logic clk;
    logic rst_n;

    swfd_in_if  link_bus ();
    swfd_out_if result_bus ();
    swfd_cfg_if cfg_bus ();

    sync_word_frame_deframer u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .link   (link_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    deframe_shadow_t shadow = new();
    int unsigned   src_idle_pct = 27;
    int unsigned   snk_idle_pct = 77;
    int unsigned   active_items = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] b,
                             input logic [CIDX_W-1:0] idx);
        if ($urandom_range(99) < src_idle_pct)
        begin
            link_bus.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
        end
        link_bus.valid         <= 1'b1;
        link_bus.command       <= cmd;
        link_bus.data_byte     <= b;
        link_bus.counter_index <= idx;
        do @(posedge clk); while (link_bus.ready !== 1'b1);
        if (shadow.note_link_item(cmd, b, idx))
            active_items++;
    endtask

    task automatic read_counter(input logic [CIDX_W-1:0] idx);
        send_item(CMD_READ, BYTE_W'($urandom_range(255)), idx);
    endtask

    task automatic send_end();
        send_item(CMD_END, BYTE_W'($urandom_range(255)), CIDX_W'($urandom_range(7)));
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        if ($urandom_range(99) < 3)
            read_counter(CIDX_W'($urandom_range(7)));
        send_item(CMD_DATA, b, CIDX_W'($urandom_range(7)));
    endtask

    // head_cut: bytes of sync word plus header actually sent
    task automatic send_frame(input logic [FIELD_W-1:0] snd, input logic [FIELD_W-1:0] sq,
                              input logic [FIELD_W-1:0] ln, input logic [TIME_W-1:0] stamp,
                              input int unsigned head_cut, input int unsigned pay_bytes,
                              input bit end_after);
        logic [111:0] hdr;
        int unsigned  i;
        hdr = {stamp, ln, sq, snd};
        for (i = 0; i < head_cut; i++)
        begin
            if (i < SYNC_BYTES)
                send_byte(SYNC_WORD[31 - 8 * i -: 8]);
            else
                send_byte(hdr[8 * (i - SYNC_BYTES) +: 8]);
        end
        repeat (pay_bytes) send_byte(BYTE_W'($urandom_range(255)));
        if (end_after)
            send_end();
    endtask

    task automatic drain();
        link_bus.valid <= 1'b0;
        while (shadow.due_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input logic [FIELD_W-1:0] payload_cap,
                             input logic [CFG_DATA_W-1:0] record_cap);
        cfg_bus.valid      <= 1'b1;
        cfg_bus.reg_index  <= REG_PAYLOAD_LIMIT;
        cfg_bus.write_data <= {16'h0000, payload_cap};
        do @(posedge clk); while (cfg_bus.ready !== 1'b1);
        shadow.set_register(REG_PAYLOAD_LIMIT, {16'h0000, payload_cap});
        cfg_bus.reg_index  <= REG_RECORD_LIMIT;
        cfg_bus.write_data <= record_cap;
        do @(posedge clk); while (cfg_bus.ready !== 1'b1);
        shadow.set_register(REG_RECORD_LIMIT, record_cap);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic random_burst();
        int unsigned r;
        int unsigned cap;
        int unsigned ln;
        int unsigned n;
        r = $urandom_range(99);
        cap = {16'h0000, shadow.len_limit};
        if (r < 80 && !shadow.at_search_start())
            send_end();
        if (r < 50)
        begin
            if ($urandom_range(3) == 0)
                repeat ($urandom_range(1, 5)) send_byte(BYTE_W'($urandom_range(255)));
            ln = $urandom_range(0, cap < 12 ? cap : 12);
            send_frame(FIELD_W'($urandom_range(65535)), FIELD_W'($urandom_range(65535)),
                       FIELD_W'(ln), {$urandom, $urandom}, HEADER_BYTES, ln, 0);
        end
        else if (r < 60 && cap < 65535)
        begin
            ln = $urandom_range(1) ? cap + 1 : $urandom_range(cap + 1, 65535);
            send_frame(FIELD_W'($urandom_range(65535)), FIELD_W'($urandom_range(65535)),
                       FIELD_W'(ln), {$urandom, $urandom}, HEADER_BYTES, 0, 0);
        end
        else if (r < 70)
        begin
            ln = (cap == 0) ? $urandom_range(1, 65535) : $urandom_range(1, cap);
            n = (ln - 1 < 6) ? ln - 1 : 6;
            send_frame(FIELD_W'($urandom_range(65535)), FIELD_W'($urandom_range(65535)),
                       FIELD_W'(ln), {$urandom, $urandom}, HEADER_BYTES,
                       $urandom_range(0, n), 1);
        end
        else if (r < 78)
            send_frame(FIELD_W'($urandom_range(65535)), FIELD_W'($urandom_range(65535)),
                       FIELD_W'($urandom_range(65535)), {$urandom, $urandom},
                       $urandom_range(1, HEADER_BYTES - 1), 0, 1);
        else if (r < 90)
        begin
            repeat ($urandom_range(1, 10)) send_byte(BYTE_W'($urandom_range(255)));
            if ($urandom_range(2) == 0)
                send_end();
        end
        else if (r < 97)
            repeat ($urandom_range(1, 4)) read_counter(CIDX_W'($urandom_range(7)));
        else
            send_item(CMD_UNUSED, BYTE_W'($urandom_range(255)), CIDX_W'($urandom_range(7)));
    endtask

    task automatic run_random(input int unsigned count);
        int unsigned base;
        base = active_items;
        while (active_items - base < count)
        begin
            random_burst();
            if ($urandom_range(49) == 0)
                drain();
        end
    endtask

    task automatic directed_items();
        int unsigned i;
        for (i = 0; i < NUM_CNT; i++)
            read_counter(CIDX_W'(i));
        send_item(CMD_UNUSED, 8'hFF, 3'h7);
        send_end();
        send_frame(16'hFFFF, 16'hFFFF, 16'h0000, '1, HEADER_BYTES, 0, 0);
        send_frame(16'h0000, 16'h0000, 16'h0001, '0, HEADER_BYTES, 1, 0);
        // end of stream inside the first window fill
        send_byte(8'h00);
        send_byte(8'hFF);
        send_end();
        // one stray byte, then a sync word found by sliding
        send_byte(8'h5A);
        send_frame(16'h1234, 16'h5678, 16'h0000, 64'h0123_4567_89AB_CDEF, HEADER_BYTES, 0, 0);
        // sync error, then end of stream while sliding
        send_byte(8'h00);
        send_byte(8'hBB);
        send_byte(8'hBB);
        send_byte(8'h01);
        send_byte(8'h00);
        send_end();
        send_frame(16'h1234, 16'h5678, 16'h0000, '0, 9, 0, 1);
        send_frame(16'hA5A5, 16'h5A5A, 16'hFFFF, {$urandom, $urandom}, HEADER_BYTES, 2, 1);
        for (i = 0; i < NUM_CNT; i++)
            read_counter(CIDX_W'(i));
    endtask

    initial
    begin
        deframe_out_t seen;
        result_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
            begin
                seen = {result_bus.kind, result_bus.payload_byte, result_bus.src_addr,
                        result_bus.sequence_number, result_bus.body_len,
                        result_bus.receive_time, result_bus.last_in_record,
                        result_bus.counter_value};
                shadow.check_output(seen);
            end
            result_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (link_bus.valid && link_bus.ready) === 1'b1 ||
                (result_bus.valid && result_bus.ready) === 1'b1 ||
                (cfg_bus.valid && cfg_bus.ready) === 1'b1)
                quiet = 0;
            else
                quiet++;
        end
        $display("** sync_word_frame_deframer: FAILED **");
        $finish;
    end

    initial
    begin
        rst_n                  <= 1'b0;
        link_bus.valid         <= 1'b0;
        link_bus.command       <= CMD_DATA;
        link_bus.data_byte     <= '0;
        link_bus.counter_index <= '0;
        cfg_bus.valid          <= 1'b0;
        cfg_bus.reg_index      <= REG_PAYLOAD_LIMIT;
        cfg_bus.write_data     <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        directed_items();
        drain();
        configure(16'h0000, 32'h0000_0000);
        send_frame(16'h0F0F, 16'hF0F0, 16'h0001, {$urandom, $urandom}, HEADER_BYTES, 0, 0);
        send_frame(16'h0F0F, 16'hF0F0, 16'h0000, {$urandom, $urandom}, HEADER_BYTES, 0, 0);
        drain();
        configure(16'hFFFF, 32'h0000_0000);
        run_random(430);

        drain();
        src_idle_pct = 77;
        snk_idle_pct = 27;
        configure(16'd8, 32'hFFFF_FFFF);
        run_random(450);
        drain();
        configure(16'h0000, 32'h0000_0000);
        run_random(100);

        drain();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        configure(16'h0001, 32'h0000_0000);
        run_random(150);

        // record limit: reach it, stay blocked, then lift it
        drain();
        configure(16'd12, shadow.tally[CNT_RECORDS] + 32'd3);
        while (!shadow.limit_hit())
            random_burst();
        repeat (6) random_burst();
        drain();
        configure(16'd12, 32'h0000_0001);
        repeat (4) random_burst();
        drain();
        configure(16'd12, 32'h0000_0000);
        run_random(100);

        drain();
        configure(16'h8000, 32'h0000_0000);
        run_random(250);
        drain();

        if (shadow.failures == 0)
            $display("** sync_word_frame_deframer: PASSED **");
        else
            $display("** sync_word_frame_deframer: FAILED **");
        $finish;
    end

endmodule

### sim.f
design/swfd_pkg.sv
design/swfd_in_if.sv
design/swfd_out_if.sv
design/swfd_cfg_if.sv
design/sync_word_frame_deframer.sv
tb/sv/sync_word_frame_deframer_test.sv
